// ----- rtl/cgi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgi_pkg
// Shared constants, types and the exp2 root table of the crack growth block.
// ----------------------------------------------------------------------------
package cgi_pkg;

	localparam int MAX_POINTS = 32;
	localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int PN_W       = 5;
	localparam int ITER_W     = 7;
	localparam int LOG_STEPS  = 24;
	localparam int EXP_STEPS  = 24;
	localparam int DIV_STEPS  = 72;
	localparam int MAC_STEPS  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_W      = 48;

	localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] REG_K_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_K_HIGH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MULT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_GROW  = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE, S_SEL, S_NORM, S_LOG, S_MULE, S_EXP, S_MHI, S_MLO, S_SCALE,
		S_STORE, S_DIVI, S_DIV, S_TLOAD, S_RD, S_MAC, S_OUT
	} cgi_state_t;

	typedef struct packed {
		logic             in_load;
		logic             sel;
		logic             norm_step;
		logic             log_step;
		logic             exp_init;
		logic             exp_step;
		logic             mul_hi;
		logic             mul_lo;
		logic             scale;
		logic             store;
		logic             div_init;
		logic             div_step;
		logic             t_load;
		logic             rd;
		logic             mac;
		logic [1:0]       mac_phase;
		logic             out_load;
		logic             out_last;
		logic             run_clear;
		logic [4:0]       tab_idx;
		logic [IDX_W-1:0] addr;
	} cgi_cmd_t;

	typedef struct packed {
		logic mid_path;
		logic norm_done;
		logic last;
		logic out_free;
	} cgi_sts_t;

	typedef logic [EXP_STEPS-1:0][31:0] exp_tab_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		logic [63:0] rem;
		res = '0;
		rem = v;
		for (int i = 0; i < 32; i++) begin
			bitv = 64'd1 << (62 - 2 * i);
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// Successive square roots of two in Q1.31: entry k holds 2^(2^-(k+1)).
	function automatic exp_tab_t exp2_table();
		exp_tab_t tab;
		logic [63:0] c;
		c = 64'd1 << 32;
		for (int k = 0; k < EXP_STEPS; k++) begin
			c = isqrt64(c << 31);
			tab[k] = c[31:0];
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP2_TAB = exp2_table();

endpackage

// ----- rtl/cgi_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgi_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module cgi_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/cgi_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgi_datapath
// Configuration registers, log2/exp2 power unit, rate store, divider,
// increment multiplier and output register.
// ----------------------------------------------------------------------------
module cgi_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [cgi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cgi_pkg::CFG_W-1:0]     cfg_data,
	input  logic [31:0]                   stress_intensity,
	input  logic                          point_active,
	input  logic                          last_point,
	input  logic                          out_stall,
	input  cgi_pkg::cgi_cmd_t             cmd,
	output cgi_pkg::cgi_sts_t             sts,
	output logic                          out_valid,
	output logic [cgi_pkg::PN_W-1:0]      point_number,
	output logic [31:0]                   crack_extension,
	output logic [47:0]                   step_time,
	output logic                          no_growth,
	output logic                          last_result
);

	logic [31:0] k_low_q, k_high_q, mgs_q;
	logic [47:0] rate_low_q, rate_high_q, mult_q;
	logic signed [31:0] exp_q;
	logic [47:0] max_q;
	logic        out_valid_q;

	logic [31:0] k_q;
	logic        active_q, last_q;
	logic [31:0] x_q;
	logic [4:0]  p_q;
	logic [23:0] frac_q;
	logic [12:0] n_q;
	logic [23:0] f_q;
	logic [31:0] r_q;
	logic [55:0] a_q;
	logic [48:0] q_q;
	logic [47:0] rate_q;
	logic [71:0] dvd_q;
	logic [47:0] rem_q;
	logic [48:0] qd_q;
	logic        dsat_q;
	logic [47:0] t_q;
	logic [95:0] acc_q;
	logic [cgi_pkg::PN_W-1:0] pn_q;
	logic [31:0] inc_q;
	logic [47:0] st_q;
	logic        ng_q, lr_q;

	logic [47:0] rd_data;

	// Point rate selection.
	logic        below_low, below_high;
	logic [47:0] direct_rate;
	always_comb begin
		below_low  = k_q < k_low_q;
		below_high = k_q < k_high_q;
		direct_rate = '0;
		if (!active_q) begin
			direct_rate = '0;
		end else if (below_low) begin
			direct_rate = rate_low_q;
		end else if (below_high) begin
			if (mult_q == '0) begin
				direct_rate = '0;
			end else if (exp_q > 0) begin
				direct_rate = '0;
			end else if (exp_q == 0) begin
				direct_rate = mult_q;
			end else begin
				direct_rate = cgi_pkg::SAT48;
			end
		end else begin
			direct_rate = rate_high_q;
		end
	end

	assign sts.mid_path  = active_q && !below_low && below_high &&
	                       (mult_q != '0) && (k_q != '0);
	assign sts.norm_done = x_q[31];
	assign sts.last      = last_q;
	assign sts.out_free  = !out_valid_q || !out_stall;

	// log2 squaring step.
	logic [63:0] sq;
	logic [32:0] sq_sh;
	assign sq    = {32'd0, x_q} * {32'd0, x_q};
	assign sq_sh = sq[63:31];

	// Exponent times log2, floored to Q.24 by dropping the low bits.
	logic signed [28:0] log_v;
	logic signed [60:0] e_ext, l_ext, ye;
	always_comb begin
		log_v = $signed({p_q ^ 5'b10000, frac_q});
		e_ext = exp_q;
		l_ext = log_v;
		ye    = e_ext * l_ext;
	end

	// exp2 fraction step.
	logic [63:0] rc;
	assign rc = {32'd0, r_q} * {32'd0, cgi_pkg::EXP2_TAB[cmd.tab_idx]};

	// Multiplier times 2^f in two partial products.
	logic [55:0] ahi;
	logic [55:0] blo;
	logic [79:0] qsum;
	assign ahi  = {8'd0, mult_q[47:24]} * {24'd0, r_q};
	assign blo  = {8'd0, mult_q[23:0]} * {24'd0, r_q};
	assign qsum = {a_q, 24'd0} + {24'd0, blo};

	// Scale by 2^n with saturation.
	logic [96:0] wide;
	logic [12:0] nneg;
	logic [48:0] shr;
	logic [47:0] scaled;
	always_comb begin
		wide   = {48'd0, q_q} << n_q[5:0];
		nneg   = -n_q;
		shr    = q_q >> nneg[5:0];
		scaled = '0;
		if (!n_q[12]) begin
			if (n_q >= 13'd48 || wide[96:48] != '0) begin
				scaled = cgi_pkg::SAT48;
			end else begin
				scaled = wide[47:0];
			end
		end else if (nneg >= 13'd64) begin
			scaled = '0;
		end else if (shr[48]) begin
			scaled = cgi_pkg::SAT48;
		end else begin
			scaled = shr[47:0];
		end
	end

	// Restoring division step.
	logic [48:0] rem_n, rem_d;
	logic        ge;
	logic [48:0] qd_n;
	always_comb begin
		rem_n = {rem_q, dvd_q[71]};
		ge    = rem_n >= {1'b0, max_q};
		rem_d = ge ? (rem_n - {1'b0, max_q}) : rem_n;
		qd_n  = {qd_q[47:0], ge};
	end

	// Increment partial products.
	logic [23:0] pa, pb;
	logic [47:0] pp;
	logic [95:0] pp_sh;
	always_comb begin
		pa = cmd.mac_phase[0] ? rd_data[47:24] : rd_data[23:0];
		pb = cmd.mac_phase[1] ? t_q[47:24] : t_q[23:0];
		pp = {24'd0, pa} * {24'd0, pb};
		unique case (cmd.mac_phase)
			2'd0:    pp_sh = {48'd0, pp};
			2'd3:    pp_sh = {pp, 48'd0};
			default: pp_sh = {24'd0, pp, 24'd0};
		endcase
	end

	logic        none;
	logic [31:0] inc_v;
	always_comb begin
		none  = max_q == '0;
		inc_v = '0;
		if (!none) begin
			inc_v = (acc_q[95:88] != '0) ? cgi_pkg::SAT32 : acc_q[87:56];
		end
	end

	cgi_ram #(.WIDTH(48), .DEPTH(cgi_pkg::MAX_POINTS)) u_rate_store (
		.clk   (clk),
		.we    (cmd.store),
		.waddr (cmd.addr),
		.wdata (rate_q),
		.re    (cmd.rd),
		.raddr (cmd.addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_low_q     <= '0;
			k_high_q    <= '0;
			rate_low_q  <= '0;
			rate_high_q <= '0;
			mult_q      <= '0;
			exp_q       <= '0;
			mgs_q       <= '0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					cgi_pkg::REG_K_LOW:     k_low_q     <= cfg_data[31:0];
					cgi_pkg::REG_K_HIGH:    k_high_q    <= cfg_data[31:0];
					cgi_pkg::REG_RATE_LOW:  rate_low_q  <= cfg_data[47:0];
					cgi_pkg::REG_RATE_HIGH: rate_high_q <= cfg_data[47:0];
					cgi_pkg::REG_MULT:      mult_q      <= cfg_data[47:0];
					cgi_pkg::REG_EXPONENT:  exp_q       <= $signed(cfg_data[31:0]);
					cgi_pkg::REG_MAX_GROW:  mgs_q       <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (cmd.run_clear) begin
				max_q <= '0;
			end else if (cmd.store && rate_q > max_q) begin
				max_q <= rate_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			k_q      <= stress_intensity;
			active_q <= point_active;
			last_q   <= last_point;
		end
		if (cmd.sel) begin
			rate_q <= direct_rate;
			x_q    <= k_q;
			p_q    <= 5'd31;
			frac_q <= '0;
		end
		if (cmd.norm_step) begin
			x_q <= {x_q[30:0], 1'b0};
			p_q <= p_q - 5'd1;
		end
		if (cmd.log_step) begin
			x_q    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
			frac_q <= {frac_q[22:0], sq_sh[32]};
		end
		if (cmd.exp_init) begin
			n_q <= ye[60:48];
			f_q <= ye[47:24];
			r_q <= 32'h8000_0000;
		end
		if (cmd.exp_step) begin
			if (f_q[23]) begin
				r_q <= rc[62:31];
			end
			f_q <= {f_q[22:0], 1'b0};
		end
		if (cmd.mul_hi) begin
			a_q <= ahi;
		end
		if (cmd.mul_lo) begin
			q_q <= qsum[79:31];
		end
		if (cmd.scale) begin
			rate_q <= scaled;
		end
		if (cmd.div_init) begin
			dvd_q  <= {mgs_q, 40'd0};
			rem_q  <= '0;
			qd_q   <= '0;
			dsat_q <= 1'b0;
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[70:0], 1'b0};
			rem_q <= rem_d[47:0];
			qd_q  <= qd_n;
			if (qd_n[48]) begin
				dsat_q <= 1'b1;
			end
		end
		if (cmd.t_load) begin
			t_q <= dsat_q ? cgi_pkg::SAT48 : qd_q[47:0];
		end
		if (cmd.mac) begin
			acc_q <= (cmd.mac_phase == 2'd0) ? pp_sh : (acc_q + pp_sh);
		end
		if (cmd.out_load) begin
			pn_q  <= cgi_pkg::PN_W'(cmd.addr);
			inc_q <= inc_v;
			st_q  <= t_q;
			ng_q  <= none;
			lr_q  <= cmd.out_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign point_number     = pn_q;
	assign crack_extension  = inc_q;
	assign step_time        = st_q;
	assign no_growth        = ng_q;
	assign last_result      = lr_q;

endmodule

// ----- rtl/cgi_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgi_ctrl
// Sequencer for per-point rate evaluation, step time division and the
// result pass over the stored rates.
// ----------------------------------------------------------------------------
module cgi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cgi_pkg::cgi_sts_t sts,
	output cgi_pkg::cgi_cmd_t cmd
);

	cgi_pkg::cgi_state_t state_q, state_n;
	logic [cgi_pkg::ITER_W-1:0] iter_q, iter_n;
	logic [cgi_pkg::CNT_W-1:0]  cnt_q, cnt_n;
	logic [cgi_pkg::IDX_W-1:0]  idx_q, idx_n;
	logic                       idx_last;

	assign in_stall = state_q != cgi_pkg::S_IDLE;
	assign idx_last = (cgi_pkg::CNT_W'(idx_q) + cgi_pkg::CNT_W'(1)) == cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cgi_pkg::S_IDLE;
			iter_q  <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			iter_q  <= iter_n;
			cnt_q   <= cnt_n;
			idx_q   <= idx_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		iter_n      = iter_q;
		cnt_n       = cnt_q;
		idx_n       = idx_q;
		cmd         = '0;
		cmd.tab_idx = iter_q[4:0];
		cmd.addr    = idx_q;
		unique case (state_q)
			cgi_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_n     = cgi_pkg::S_SEL;
				end
			end
			cgi_pkg::S_SEL: begin
				if (cnt_q >= cgi_pkg::CNT_W'(cgi_pkg::MAX_POINTS)) begin
					// The point is dropped, but a last mark still closes the run.
					state_n = sts.last ? cgi_pkg::S_DIVI : cgi_pkg::S_IDLE;
				end else begin
					cmd.sel = 1'b1;
					state_n = sts.mid_path ? cgi_pkg::S_NORM : cgi_pkg::S_STORE;
				end
			end
			cgi_pkg::S_NORM: begin
				if (sts.norm_done) begin
					iter_n  = '0;
					state_n = cgi_pkg::S_LOG;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			cgi_pkg::S_LOG: begin
				cmd.log_step = 1'b1;
				iter_n       = iter_q + 1'b1;
				if (iter_q == cgi_pkg::ITER_W'(cgi_pkg::LOG_STEPS - 1)) begin
					state_n = cgi_pkg::S_MULE;
				end
			end
			cgi_pkg::S_MULE: begin
				cmd.exp_init = 1'b1;
				iter_n       = '0;
				state_n      = cgi_pkg::S_EXP;
			end
			cgi_pkg::S_EXP: begin
				cmd.exp_step = 1'b1;
				iter_n       = iter_q + 1'b1;
				if (iter_q == cgi_pkg::ITER_W'(cgi_pkg::EXP_STEPS - 1)) begin
					state_n = cgi_pkg::S_MHI;
				end
			end
			cgi_pkg::S_MHI: begin
				cmd.mul_hi = 1'b1;
				state_n    = cgi_pkg::S_MLO;
			end
			cgi_pkg::S_MLO: begin
				cmd.mul_lo = 1'b1;
				state_n    = cgi_pkg::S_SCALE;
			end
			cgi_pkg::S_SCALE: begin
				cmd.scale = 1'b1;
				state_n   = cgi_pkg::S_STORE;
			end
			cgi_pkg::S_STORE: begin
				cmd.store = 1'b1;
				cmd.addr  = cnt_q[cgi_pkg::IDX_W-1:0];
				cnt_n     = cnt_q + 1'b1;
				state_n   = sts.last ? cgi_pkg::S_DIVI : cgi_pkg::S_IDLE;
			end
			cgi_pkg::S_DIVI: begin
				cmd.div_init = 1'b1;
				iter_n       = '0;
				state_n      = cgi_pkg::S_DIV;
			end
			cgi_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				iter_n       = iter_q + 1'b1;
				if (iter_q == cgi_pkg::ITER_W'(cgi_pkg::DIV_STEPS - 1)) begin
					state_n = cgi_pkg::S_TLOAD;
				end
			end
			cgi_pkg::S_TLOAD: begin
				cmd.t_load = 1'b1;
				idx_n      = '0;
				state_n    = cgi_pkg::S_RD;
			end
			cgi_pkg::S_RD: begin
				cmd.rd  = 1'b1;
				iter_n  = '0;
				state_n = cgi_pkg::S_MAC;
			end
			cgi_pkg::S_MAC: begin
				cmd.mac       = 1'b1;
				cmd.mac_phase = iter_q[1:0];
				iter_n        = iter_q + 1'b1;
				if (iter_q == cgi_pkg::ITER_W'(cgi_pkg::MAC_STEPS - 1)) begin
					state_n = cgi_pkg::S_OUT;
				end
			end
			cgi_pkg::S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = idx_last;
					if (idx_last) begin
						cmd.run_clear = 1'b1;
						cnt_n         = '0;
						state_n       = cgi_pkg::S_IDLE;
					end else begin
						idx_n   = idx_q + 1'b1;
						state_n = cgi_pkg::S_RD;
					end
				end
			end
			default: state_n = cgi_pkg::S_IDLE;
		endcase
	end

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cgi_pkg::S_DIV |-> iter_q < cgi_pkg::ITER_W'(cgi_pkg::DIV_STEPS))
		else $error("division ran past its step count");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cgi_pkg::S_RD |-> cgi_pkg::CNT_W'(idx_q) < cnt_q)
		else $error("result index beyond stored point count");

	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cgi_pkg::S_IDLE && in_valid) |=> state_q == cgi_pkg::S_SEL)
		else $error("accepted request not evaluated");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a pending result");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |=> cnt_q <= cgi_pkg::CNT_W'(cgi_pkg::MAX_POINTS))
		else $error("point count overflow");

endmodule

// ----- rtl/crack_growth_increment.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crack_growth_increment
// Stress corrosion crack growth: per-point power law rates, step time from
// the largest rate, and one growth increment per stored point.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// cfg      cfg_write             cfg_index, cfg_data
// in       in_valid / in_stall   stress_intensity, point_active, last_point
// out      out_valid / out_stall point_number, crack_extension, step_time,
//                                no_growth, last_result
//
// Outside the middle band a point goes from rate selection straight to the
// store; in the middle band its time is set by the normalize shift, then 24
// log2 squarings and 24 exp2 steps, each kind on its own 32x32 multiplier.
// The last point adds a bit-serial division, then takes each result through the
// 24x24 increment multiplier and output register.
// Reset clears the control and configuration state; the rate store needs none.
// A stalled output holds the result pass; no request is taken during a run.
// ----------------------------------------------------------------------------
module crack_growth_increment (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [cgi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cgi_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [31:0]                   stress_intensity,
	input  logic                          point_active,
	input  logic                          last_point,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cgi_pkg::PN_W-1:0]      point_number,
	output logic [31:0]                   crack_extension,
	output logic [47:0]                   step_time,
	output logic                          no_growth,
	output logic                          last_result
);

	cgi_pkg::cgi_cmd_t cmd;
	cgi_pkg::cgi_sts_t sts;

	cgi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cgi_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.stress_intensity (stress_intensity),
		.point_active     (point_active),
		.last_point       (last_point),
		.out_stall        (out_stall),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (out_valid),
		.point_number     (point_number),
		.crack_extension  (crack_extension),
		.step_time        (step_time),
		.no_growth        (no_growth),
		.last_result      (last_result)
	);

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crack_growth_increment: crack fronts are sent
// through the valid/stall input channel, each increment is predicted from
// the growth law and compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [47:0] ALL48 = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] k;
		logic        act;
		logic        lst;
	} front_point_t;

	typedef struct packed {
		logic [4:0]  pn;
		logic [31:0] inc;
		logic [47:0] st;
		logic        ng;
		logic        lr;
	} increment_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [cgi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cgi_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] stress_intensity = '0;
	logic point_active = 1'b0;
	logic last_point = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [cgi_pkg::PN_W-1:0] point_number;
	logic [31:0] crack_extension;
	logic [47:0] step_time;
	logic no_growth;
	logic last_result;

	crack_growth_increment dut (.*);

	always #5 clk = ~clk;

	// Local copy of the register file.
	logic [31:0] k_low_q, k_high_q, max_grow_q;
	logic [47:0] rate_low_q, rate_high_q, mult_q;
	logic signed [31:0] expo_q;

	// Predicted front state.
	logic [47:0] front_rates [32];
	logic [47:0] peak_rate;
	int front_len;
	logic [31:0] root_chain [24];

	front_point_t pending_points[$];
	increment_t expected_increments[$];
	int errors = 0, points_sent = 0, increments_seen = 0, fronts_done = 0;
	int gap_left = 0, stall_left = 0, idle_cycles = 0;
	bit quiet = 0;

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] lo, hi, mid;
		lo = 0;
		hi = 64'hFFFF_FFFF;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint log2_of_k(logic [31:0] k);
		int p;
		logic [63:0] x;
		longint frac;
		p = 31;
		frac = 0;
		while (!k[p]) p--;
		x = 64'(k) << (31 - p);
		for (int i = 0; i < 24; i++) begin
			x = (x * x) >> 31;
			frac = frac << 1;
			if (x >= 64'h1_0000_0000) begin
				x = x >> 1;
				frac = frac | 1;
			end
		end
		return longint'(p - 16) * 16777216 + frac;
	endfunction

	function automatic logic [47:0] power_band_rate(logic [31:0] k);
		longint y, n;
		logic [63:0] m, a, b, q;
		if (mult_q == 0) return '0;
		if (k == 0) begin
			if (expo_q > 0) return '0;
			if (expo_q == 0) return mult_q;
			return ALL48;
		end
		y = (longint'(expo_q) * log2_of_k(k)) >>> 24;
		n = y >>> 24;
		m = 64'h8000_0000;
		for (int j = 1; j <= 24; j++)
			if (y[24 - j]) m = (m * root_chain[j - 1]) >> 31;
		a = 64'(mult_q[47:24]) * m;
		b = 64'(mult_q[23:0]) * m;
		q = (a >> 7) + ((((a & 64'd127) << 24) + b) >> 31);
		if (n >= 0) begin
			if (n >= 48 || q > (64'(ALL48) >> n)) return ALL48;
			q = q << n;
		end else begin
			if (-n >= 64) return '0;
			q = q >> (-n);
		end
		return (q > 64'(ALL48)) ? ALL48 : q[47:0];
	endfunction

	function automatic logic [47:0] time_to_max_growth();
		logic [63:0] rem, q;
		rem = 0;
		q = 0;
		for (int i = 71; i >= 0; i--) begin
			rem = (rem << 1) | ((i >= 40) ? 64'(max_grow_q[i - 40]) : 64'd0);
			q = q << 1;
			if (rem >= 64'(peak_rate)) begin
				rem = rem - 64'(peak_rate);
				q = q | 1;
			end
			if (q > 64'(ALL48)) return ALL48;
		end
		return q[47:0];
	endfunction

	function automatic void take_point(front_point_t p);
		logic [47:0] r, t;
		logic [95:0] prod;
		increment_t e;
		bit none;
		if (front_len < cgi_pkg::MAX_POINTS) begin
			if (!p.act) r = '0;
			else if (p.k < k_low_q) r = rate_low_q;
			else if (p.k < k_high_q) r = power_band_rate(p.k);
			else r = rate_high_q;
			front_rates[front_len] = r;
			if (r > peak_rate) peak_rate = r;
			front_len++;
		end
		if (!p.lst) return;
		none = (peak_rate == 0);
		t = none ? ALL48 : time_to_max_growth();
		for (int i = 0; i < front_len; i++) begin
			prod = 96'(front_rates[i]) * 96'(t);
			prod = prod >> 56;
			e.pn = i[4:0];
			e.inc = none ? 32'd0 : ((prod > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0]);
			e.st = t;
			e.ng = none;
			e.lr = (i + 1 == front_len);
			expected_increments.push_back(e);
		end
		front_len = 0;
		peak_rate = '0;
		fronts_done++;
	endfunction

	// Driver: one request per free cycle, with random idle bursts.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			take_point('{stress_intensity, point_active, last_point});
			points_sent++;
		end
		if (in_valid && in_stall) begin
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			gap_left = $urandom_range(0, 5);
			in_valid <= 1'b0;
		end else if (pending_points.size() > 0) begin
			front_point_t p;
			p = pending_points.pop_front();
			stress_intensity <= p.k;
			point_active <= p.act;
			last_point <= p.lst;
			in_valid <= 1'b1;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Monitor and output stall generator.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			increments_seen++;
			if (expected_increments.size() == 0) begin
				$error("unexpected increment for point %0d", point_number);
				errors++;
			end else begin
				increment_t e;
				e = expected_increments.pop_front();
				if (point_number !== e.pn) begin
					$error("point_number: expected %0d, got %0d", e.pn, point_number);
					errors++;
				end
				if (crack_extension !== e.inc) begin
					$error("crack_extension: expected %h, got %h", e.inc, crack_extension);
					errors++;
				end
				if (step_time !== e.st) begin
					$error("step_time: expected %h, got %h", e.st, step_time);
					errors++;
				end
				if (no_growth !== e.ng) begin
					$error("no_growth: expected %b, got %b", e.ng, no_growth);
					errors++;
				end
				if (last_result !== e.lr) begin
					$error("last_result: expected %b, got %b", e.lr, last_result);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 5);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(logic [cgi_pkg::CFG_IDX_W-1:0] idx, logic [47:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			cgi_pkg::REG_K_LOW:     k_low_q = value[31:0];
			cgi_pkg::REG_K_HIGH:    k_high_q = value[31:0];
			cgi_pkg::REG_RATE_LOW:  rate_low_q = value;
			cgi_pkg::REG_RATE_HIGH: rate_high_q = value;
			cgi_pkg::REG_MULT:      mult_q = value;
			cgi_pkg::REG_EXPONENT:  expo_q = value[31:0];
			cgi_pkg::REG_MAX_GROW:  max_grow_q = value[31:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_law(logic [31:0] kl, logic [31:0] kh, logic [47:0] rl, logic [47:0] rh,
			logic [47:0] mul, logic [31:0] ex, logic [31:0] mg);
		write_reg(cgi_pkg::REG_K_LOW, 48'(kl));
		write_reg(cgi_pkg::REG_K_HIGH, 48'(kh));
		write_reg(cgi_pkg::REG_RATE_LOW, rl);
		write_reg(cgi_pkg::REG_RATE_HIGH, rh);
		write_reg(cgi_pkg::REG_MULT, mul);
		write_reg(cgi_pkg::REG_EXPONENT, 48'(ex));
		write_reg(cgi_pkg::REG_MAX_GROW, 48'(mg));
	endtask

	// Holds off further requests until the block has drained its front.
	task automatic drain();
		do @(posedge clk);
		while (pending_points.size() > 0 || expected_increments.size() > 0 || in_valid);
		repeat (30) @(posedge clk);
	endtask

	task automatic add_point(logic [31:0] k, logic act, logic lst);
		pending_points.push_back('{k, act, lst});
	endtask

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [31:0] rand_k();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return k_low_q + $urandom_range(0, 32'h0004_0000);
			2: return $urandom_range(0, 32'h0010_0000);
			default: return k_high_q - $urandom_range(0, 32'h0000_1000);
		endcase
	endfunction

	initial begin
		logic [31:0] kl;
		int len;
		c_init: begin
			logic [63:0] c;
			c = 64'h1_0000_0000;
			for (int j = 0; j < 24; j++) begin
				c = floor_sqrt(c << 31);
				root_chain[j] = c[31:0];
			end
		end
		k_low_q = 0; k_high_q = 0; rate_low_q = 0; rate_high_q = 0;
		mult_q = 0; expo_q = 0; max_grow_q = 0;
		peak_rate = 0;
		front_len = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// All three bands and the extremes of the stress intensity.
		set_law(32'h0001_0000, 32'h0010_0000, 48'h0000_0100_0000, 48'h0100_0000_0000,
			48'h0100_0000_0000, 32'h0200_0000, 32'h0001_0000);
		add_point(32'h0, 1'b1, 1'b0);
		add_point(32'h0002_8000, 1'b1, 1'b0);
		add_point(32'h0000_FFFF, 1'b0, 1'b0);
		add_point(32'h0010_0000, 1'b1, 1'b0);
		add_point(32'hFFFF_FFFF, 1'b1, 1'b1);
		drain();
		// Zero intensity in the middle band, exponent above, at and below zero.
		set_law(32'h0, 32'hFFFF_FFFF, 48'h1, ALL48, 48'h0000_0300_0000, 32'h0180_0000,
			32'hFFFF_FFFF);
		add_point(32'h0, 1'b1, 1'b0);
		add_point(32'h0000_0001, 1'b1, 1'b1);
		drain();
		write_reg(cgi_pkg::REG_EXPONENT, 48'h0);
		add_point(32'h0, 1'b1, 1'b1);
		drain();
		write_reg(cgi_pkg::REG_EXPONENT, 48'h0000_8000_0000);
		add_point(32'h0, 1'b1, 1'b0);
		add_point(32'h7FFF_0000, 1'b1, 1'b1);
		drain();
		// Zero multiplier, then band edges out of order.
		set_law(32'h0, 32'hFFFF_FFFF, 48'h0, 48'h0, 48'h0, 32'h7FFF_FFFF, 32'h0);
		add_point(32'h0001_0000, 1'b1, 1'b0);
		add_point(32'h0, 1'b0, 1'b1);
		drain();
		set_law(32'h0008_0000, 32'h0001_0000, 48'h0000_1000_0000, 48'h00FF_0000_0000,
			48'h0100_0000_0000, 32'h0100_0000, 32'h0001_0000);
		add_point(32'h0000_8000, 1'b1, 1'b0);
		add_point(32'h0004_0000, 1'b1, 1'b0);
		add_point(32'h0008_0000, 1'b1, 1'b1);
		drain();
		// Front of inactive points only, then an overlong front.
		add_point(32'h0009_0000, 1'b0, 1'b0);
		add_point(32'hFFFF_FFFF, 1'b0, 1'b1);
		drain();
		for (int i = 0; i < 36; i++) add_point($urandom, 1'b1, i == 35);
		drain();

		// Random laws, each with several fronts.
		while (points_sent < 330) begin
			if (points_sent > 270) quiet = 1;
			kl = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000);
			set_law(kl, ($urandom_range(0, 4) == 0) ? $urandom : kl + $urandom_range(1, 32'h0100_0000),
				rand48() >> $urandom_range(0, 30), rand48() >> $urandom_range(0, 20),
				($urandom_range(0, 9) == 0) ? 48'h0 : rand48() >> $urandom_range(0, 24),
				($urandom_range(0, 4) == 0) ? $urandom
					: $urandom_range(0, 32'h0800_0000) - 32'h0400_0000,
				$urandom);
			for (int f = 0; f < 4; f++) begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(32, 35) : $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					add_point(rand_k(), $urandom_range(0, 3) != 0, i == len - 1);
				if (f == 1) drain();
			end
			drain();
		end

		$display("Sent %0d front points in %0d fronts, checked %0d increments.",
			points_sent, fronts_done, increments_seen);
		$display("Covered all bands, zero-rate fronts, overlong fronts and edge laws.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/cgi_pkg.sv
rtl/cgi_ram.sv
rtl/cgi_datapath.sv
rtl/cgi_ctrl.sv
rtl/crack_growth_increment.sv
test/tb.sv
